@@ rtl/core/mtg_pkg.sv @@
`timescale 1ns / 1ps

package mtg_pkg;

   // Store geometry
   localparam int STATE_DEPTH  = 624;
   localparam int TWIST_OFFSET = 397;
   localparam int IDX_W        = $clog2(STATE_DEPTH + 2);
   localparam int WORD_W       = 32;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [WORD_W-1:0] word_type;

   // Position codes and index limits
   localparam idx_type POS_RETWIST  = idx_type'(STATE_DEPTH);
   localparam idx_type POS_UNSEEDED = idx_type'(STATE_DEPTH + 1);
   localparam idx_type LAST_IDX     = idx_type'(STATE_DEPTH - 1);
   localparam idx_type FAR_SPLIT    = idx_type'(STATE_DEPTH - TWIST_OFFSET);
   localparam idx_type FAR_FWD      = idx_type'(TWIST_OFFSET);

   // Algorithm constants
   localparam word_type TWIST_MATRIX = 32'h9908_b0df;
   localparam word_type HIGH_BIT     = 32'h8000_0000;
   localparam word_type LOW_BITS     = 32'h7fff_ffff;
   localparam word_type SEED_MULT    = 32'd1812433253;
   localparam word_type TEMPER_B     = 32'h9d2c_5680;
   localparam word_type TEMPER_C     = 32'hefc6_0000;
   localparam word_type DEFAULT_SEED = 32'd5489;

   // Operation codes
   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_SEED = 1'b1;

   // State store write request
   typedef struct packed {
      logic     en;
      idx_type  addr;
      word_type data;
   } ram_wr_type;

   // State store read request: neighbor word and far word
   typedef struct packed {
      logic    en;
      idx_type addr_next;
      idx_type addr_far;
   } ram_rd_type;

   // One step of the twist recurrence
   function automatic word_type twist_word(input word_type upper,
                                           input word_type lower,
                                           input word_type far_word);
      word_type y;
      word_type v;
      y = (upper & HIGH_BIT) | (lower & LOW_BITS);
      v = far_word ^ (y >> 1);
      if (y[0]) begin
         v = v ^ TWIST_MATRIX;
      end
      return v;
   endfunction

   // Output tempering
   function automatic word_type temper_word(input word_type w);
      word_type y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

@@ rtl/core/mtg_state_ram.sv @@
`timescale 1ns / 1ps

module mtg_state_ram (
   input  logic                 clock,
   input  mtg_pkg::ram_wr_type  ram_wr,
   input  mtg_pkg::ram_rd_type  ram_rd,
   output mtg_pkg::word_type    rd_next,
   output mtg_pkg::word_type    rd_far
);

   mtg_pkg::word_type mem [0:mtg_pkg::STATE_DEPTH-1];
   mtg_pkg::word_type rd_next_ff;
   mtg_pkg::word_type rd_far_ff;

   // Single write port
   always_ff @(posedge clock) begin
      if (ram_wr.en) begin
         mem[ram_wr.addr] <= ram_wr.data;
      end
   end

   // Two registered read ports, held when not enabled
   always_ff @(posedge clock) begin
      if (ram_rd.en) begin
         rd_next_ff <= mem[ram_rd.addr_next];
         rd_far_ff  <= mem[ram_rd.addr_far];
      end
   end

   assign rd_next = rd_next_ff;
   assign rd_far  = rd_far_ff;

endmodule

@@ rtl/core/mtg_seed_mult.sv @@
`timescale 1ns / 1ps

module mtg_seed_mult (
   input  logic               clock,
   input  logic               mult_en,
   input  mtg_pkg::word_type  prev_word,
   output mtg_pkg::word_type  mult_prod
);

   mtg_pkg::word_type mix;
   mtg_pkg::word_type prod_in;
   mtg_pkg::word_type prod_ff;

   // Seeding recurrence: low half of SEED_MULT * (prev ^ (prev >> 30))
   assign mix     = prev_word ^ (prev_word >> 30);
   assign prod_in = mtg_pkg::SEED_MULT * mix;

   always_ff @(posedge clock) begin
      if (mult_en) begin
         prod_ff <= prod_in;
      end
   end

   assign mult_prod = prod_ff;

endmodule

@@ rtl/core/mersenne_twister_generator_core.sv @@
`timescale 1ns / 1ps

// MT19937 32-bit generator core.
// Request channel (req_valid/req_ready): req_operation selects a draw (0) or a
// reseed with req_seed_value (1). Result channel (rsp_valid/rsp_ready): one
// tempered word rsp_random_word per draw; a reseed yields no transaction.
// The 624-word state lives in one RAM with two registered read ports. Each
// draw twists exactly one word on the fly: it reads the neighbor word and the
// far word, writes back the new word and tempers it for output.
// Draw: on acceptance the RAM reads are registered; the twist step then writes
// back the new word and registers the tempered result, and the block returns
// to idle before it takes the next request, so draws do not overlap.
// Reseed: the seeding loop runs through the 32x32 multiplier, with a multiply
// step and an add-and-write step per word; the block is busy until word 623 is written.
// A draw before any seed first seeds with 5489 and then completes as a draw.
// Reset clears the position to "never seeded"; the RAM is not cleared.
// A stalled result stays in the output register; one more draw may be taken
// meanwhile, and it holds in the twist step until the output register frees up.
module mersenne_twister_generator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [31:0] req_seed_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_random_word
);

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_SEED_MUL = 2'd1;
   localparam logic [1:0] ST_SEED_ADD = 2'd2;
   localparam logic [1:0] ST_TWIST    = 2'd3;

   logic [1:0]          state_ff, state_in;
   mtg_pkg::idx_type    pos_ff, pos_in;
   mtg_pkg::idx_type    idx_ff, idx_in;
   mtg_pkg::idx_type    seed_idx_ff, seed_idx_in;
   logic                op_ff, op_in;
   mtg_pkg::word_type   prev_ff, prev_in;
   mtg_pkg::word_type   cur_ff, cur_in;
   mtg_pkg::word_type   first_ff, first_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mtg_pkg::word_type   rsp_word_ff, rsp_word_in;

   mtg_pkg::ram_wr_type ram_wr;
   mtg_pkg::ram_rd_type ram_rd;
   mtg_pkg::idx_type    rd_index;
   mtg_pkg::word_type   rd_next;
   mtg_pkg::word_type   rd_far;
   mtg_pkg::word_type   mult_prod;
   logic                mult_en;
   mtg_pkg::word_type   seed_sel;
   mtg_pkg::word_type   seed_word;
   mtg_pkg::word_type   twist_lower;
   mtg_pkg::word_type   twist_v;

   mtg_state_ram u_state_ram (
      .clock   (clock),
      .ram_wr  (ram_wr),
      .ram_rd  (ram_rd),
      .rd_next (rd_next),
      .rd_far  (rd_far)
   );

   mtg_seed_mult u_seed_mult (
      .clock     (clock),
      .mult_en   (mult_en),
      .prev_word (prev_ff),
      .mult_prod (mult_prod)
   );

   // Datapath terms
   assign seed_sel    = (req_operation == mtg_pkg::OP_SEED) ? req_seed_value
                                                            : mtg_pkg::DEFAULT_SEED;
   assign seed_word   = mult_prod + mtg_pkg::word_type'(seed_idx_ff);
   // last word of a generation pairs with the new word 0
   assign twist_lower = (idx_ff == mtg_pkg::LAST_IDX) ? first_ff : rd_next;
   assign twist_v     = mtg_pkg::twist_word(cur_ff, twist_lower, rd_far);

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      seed_idx_in  = seed_idx_ff;
      op_in        = op_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      ram_wr       = '0;
      rd_index     = '0;
      mult_en      = 1'b0;
      ram_rd.en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_operation;
               if (req_operation == mtg_pkg::OP_SEED ||
                   pos_ff == mtg_pkg::POS_UNSEEDED) begin
                  // start seeding: word 0 is the seed itself
                  ram_wr.en   = 1'b1;
                  ram_wr.addr = '0;
                  ram_wr.data = seed_sel;
                  prev_in     = seed_sel;
                  cur_in      = seed_sel;
                  seed_idx_in = mtg_pkg::idx_type'(1);
                  state_in    = ST_SEED_MUL;
               end else begin
                  rd_index  = (pos_ff >= mtg_pkg::POS_RETWIST) ? '0 : pos_ff;
                  ram_rd.en = 1'b1;
                  idx_in    = rd_index;
                  state_in  = ST_TWIST;
               end
            end
         end
         ST_SEED_MUL: begin
            mult_en  = 1'b1;
            state_in = ST_SEED_ADD;
         end
         ST_SEED_ADD: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = seed_idx_ff;
            ram_wr.data = seed_word;
            prev_in     = seed_word;
            if (seed_idx_ff == mtg_pkg::LAST_IDX) begin
               pos_in = mtg_pkg::POS_RETWIST;
               if (op_ff == mtg_pkg::OP_DRAW) begin
                  // implicit seed done, continue with word 0
                  rd_index  = '0;
                  ram_rd.en = 1'b1;
                  idx_in    = '0;
                  state_in  = ST_TWIST;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               seed_idx_in = seed_idx_ff + mtg_pkg::idx_type'(1);
               state_in    = ST_SEED_MUL;
            end
         end
         ST_TWIST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ram_wr.en    = 1'b1;
               ram_wr.addr  = idx_ff;
               ram_wr.data  = twist_v;
               if (idx_ff == '0) begin
                  first_in = twist_v;
               end
               cur_in       = twist_lower;
               pos_in       = idx_ff + mtg_pkg::idx_type'(1);
               rsp_valid_in = 1'b1;
               rsp_word_in  = mtg_pkg::temper_word(twist_v);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // neighbor and far addresses of the word being twisted
      ram_rd.addr_next = (rd_index == mtg_pkg::LAST_IDX) ? '0
                                                         : rd_index + mtg_pkg::idx_type'(1);
      ram_rd.addr_far  = (rd_index < mtg_pkg::FAR_SPLIT) ? rd_index + mtg_pkg::FAR_FWD
                                                         : rd_index - mtg_pkg::FAR_SPLIT;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= mtg_pkg::POS_UNSEEDED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      seed_idx_ff <= seed_idx_in;
      op_ff       <= op_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      first_ff    <= first_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Position never leaves its legal range
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= mtg_pkg::POS_UNSEEDED)
      else $error("position out of range");

   // A RAM write never hits an entry being read in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      (ram_wr.en && ram_rd.en) |->
         (ram_wr.addr != ram_rd.addr_next && ram_wr.addr != ram_rd.addr_far))
      else $error("read and write collide in state store");

   // A draw on a seeded store goes straight to the twist step
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_operation == mtg_pkg::OP_DRAW &&
       pos_ff != mtg_pkg::POS_UNSEEDED) |=> (state_ff == ST_TWIST))
      else $error("draw did not enter twist step");

   // Seeding index stays within the words after word 0
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEED_MUL || state_ff == ST_SEED_ADD) |->
         (seed_idx_ff != '0 && seed_idx_ff <= mtg_pkg::LAST_IDX))
      else $error("seeding index out of range");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_LIMIT  = 20_000;
   localparam int RANDOM_ITEMS = 230;
   localparam int LONG_BURST   = 200;
   localparam int MAX_REPORTS  = 10;

   // One directed transaction; pinned rows carry a hand-written expected word
   typedef struct packed {
      logic              op;
      mtg_pkg::word_type seed;
      logic              pinned;
      mtg_pkg::word_type pinned_word;
   } row_type;

   localparam int N_ROWS = 22;
   localparam row_type DIRECTED[N_ROWS] = '{
      '{mtg_pkg::OP_DRAW, 32'h0000_0000, 1'b1, 32'd3499211612},  // draw before any seed
      '{mtg_pkg::OP_DRAW, 32'hffff_ffff, 1'b1, 32'd581869302},
      '{mtg_pkg::OP_DRAW, 32'h0000_0000, 1'b1, 32'd3890346734},
      '{mtg_pkg::OP_DRAW, 32'hffff_ffff, 1'b1, 32'd3586334585},
      '{mtg_pkg::OP_DRAW, 32'h1234_5678, 1'b1, 32'd545404204},
      '{mtg_pkg::OP_SEED, 32'h0000_0001, 1'b0, 32'h0},
      '{mtg_pkg::OP_DRAW, 32'h0000_0000, 1'b1, 32'd1791095845},
      '{mtg_pkg::OP_DRAW, 32'h0000_0000, 1'b1, 32'd4282876139},
      '{mtg_pkg::OP_SEED, 32'h0000_0000, 1'b0, 32'h0},
      '{mtg_pkg::OP_DRAW, 32'hffff_ffff, 1'b0, 32'h0},
      '{mtg_pkg::OP_SEED, 32'hffff_ffff, 1'b0, 32'h0},
      '{mtg_pkg::OP_DRAW, 32'h0000_0000, 1'b0, 32'h0},
      '{mtg_pkg::OP_SEED, 32'haaaa_aaaa, 1'b0, 32'h0},
      '{mtg_pkg::OP_SEED, 32'h5555_5555, 1'b0, 32'h0},          // back-to-back reseeds
      '{mtg_pkg::OP_DRAW, 32'haaaa_aaaa, 1'b0, 32'h0},
      '{mtg_pkg::OP_DRAW, 32'h5555_5555, 1'b0, 32'h0},
      '{mtg_pkg::OP_SEED, 32'd5489,      1'b0, 32'h0},          // explicit default seed
      '{mtg_pkg::OP_DRAW, 32'h0000_0000, 1'b1, 32'd3499211612},
      '{mtg_pkg::OP_SEED, 32'h8000_0000, 1'b0, 32'h0},
      '{mtg_pkg::OP_DRAW, 32'h0000_0000, 1'b0, 32'h0},
      '{mtg_pkg::OP_SEED, 32'h7fff_ffff, 1'b0, 32'h0},
      '{mtg_pkg::OP_DRAW, 32'hffff_ffff, 1'b0, 32'h0}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_operation;
   logic [31:0] req_seed_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_random_word;

   mersenne_twister_generator_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_seed_value  (req_seed_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_random_word (rsp_random_word)
   );

   // Generator shadow state
   mtg_pkg::word_type gen_store[mtg_pkg::STATE_DEPTH];
   logic [9:0]        gen_pos;

   mtg_pkg::word_type pending_words[$];

   int  cycle_count   = 0;
   int  fail_count    = 0;
   int  checked_count = 0;
   int  draws_sent    = 0;
   int  seeds_sent    = 0;
   int  regen_count   = 0;
   int  stall_left    = 0;
   bit  src_gaps_on   = 1'b0;
   bit  sink_stalls_on = 1'b0;

   always #4 clock = ~clock;

   // Multiplicative seeding recurrence over the whole store
   function automatic void seed_gen_store(input mtg_pkg::word_type s);
      mtg_pkg::word_type p;
      gen_store[0] = s;
      for (int k = 1; k < mtg_pkg::STATE_DEPTH; k++) begin
         p = gen_store[k-1];
         gen_store[k] = mtg_pkg::SEED_MULT * (p ^ (p >> 30)) + mtg_pkg::word_type'(k);
      end
      gen_pos = 10'(mtg_pkg::STATE_DEPTH);
   endfunction

   // Full regeneration of the store
   function automatic void regen_store();
      int                nxt;
      int                far;
      mtg_pkg::word_type mix;
      mtg_pkg::word_type v;
      for (int k = 0; k < mtg_pkg::STATE_DEPTH; k++) begin
         nxt = (k + 1) % mtg_pkg::STATE_DEPTH;
         far = (k + mtg_pkg::TWIST_OFFSET) % mtg_pkg::STATE_DEPTH;
         mix = (gen_store[k] & mtg_pkg::HIGH_BIT) | (gen_store[nxt] & mtg_pkg::LOW_BITS);
         v = gen_store[far] ^ (mix >> 1);
         if (mix[0]) begin
            v = v ^ mtg_pkg::TWIST_MATRIX;
         end
         gen_store[k] = v;
      end
      gen_pos = '0;
      regen_count++;
   endfunction

   // Next tempered word; seeds with the default first if never seeded
   function automatic mtg_pkg::word_type next_word();
      mtg_pkg::word_type t;
      if (gen_pos >= mtg_pkg::STATE_DEPTH) begin
         if (gen_pos != mtg_pkg::STATE_DEPTH) begin
            seed_gen_store(mtg_pkg::DEFAULT_SEED);
         end
         regen_store();
      end
      t = gen_store[gen_pos];
      gen_pos = gen_pos + 1'b1;
      t = t ^ (t >> 11);
      t = t ^ ((t << 7) & mtg_pkg::TEMPER_B);
      t = t ^ ((t << 15) & mtg_pkg::TEMPER_C);
      t = t ^ (t >> 18);
      return t;
   endfunction

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("[%0t] ERROR: %s", $realtime, what);
      end
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap(input bit on);
      int r;
      r = $urandom_range(0, 99);
      if (!on || r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Present one request transaction and predict its outcome on acceptance
   task automatic drive_request(input logic op, input mtg_pkg::word_type seed,
                                input logic pinned, input mtg_pkg::word_type pinned_word);
      int                gap;
      mtg_pkg::word_type w;
      gap = pick_gap(src_gaps_on);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_operation  = op;
      req_seed_value = seed;
      do @(posedge clock); while (!req_ready);
      if (op == mtg_pkg::OP_SEED) begin
         seed_gen_store(seed);
         seeds_sent++;
      end else begin
         w = next_word();
         pending_words.push_back(pinned ? pinned_word : w);
         draws_sent++;
      end
      @(negedge clock);
   endtask

   task automatic wait_all_results();
      req_valid = 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
   endtask

   function automatic mtg_pkg::word_type pick_seed();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 32'h0000_0000;
      end
      if (r == 1) begin
         return 32'hffff_ffff;
      end
      return $urandom;
   endfunction

   // Cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Result-side backpressure
   always @(negedge clock) begin
      if (!sink_stalls_on) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 20) begin
         rsp_ready  <= 1'b0;
         stall_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result checker
   always @(posedge clock) begin
      mtg_pkg::word_type exp_word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            note_failure($sformatf("unexpected result %08h", rsp_random_word));
         end else begin
            exp_word = pending_words.pop_front();
            checked_count++;
            if (rsp_random_word !== exp_word) begin
               note_failure($sformatf("random_word expected %08h got %08h",
                                      exp_word, rsp_random_word));
            end
         end
      end
   end

   // Stimulus
   initial begin
      int rand_items;
      int burst_len;
      int drain_wait;
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = mtg_pkg::OP_DRAW;
      req_seed_value = '0;
      rsp_ready      = 1'b0;
      rand_items     = 0;
      gen_pos        = 10'(mtg_pkg::STATE_DEPTH + 1);
      for (int k = 0; k < mtg_pkg::STATE_DEPTH; k++) begin
         gen_store[k] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table, first with no idling then with gaps on both sides
      for (int i = 0; i < N_ROWS; i++) begin
         src_gaps_on    = (i >= N_ROWS / 2);
         sink_stalls_on = (i >= N_ROWS / 2);
         drive_request(DIRECTED[i].op, DIRECTED[i].seed,
                       DIRECTED[i].pinned, DIRECTED[i].pinned_word);
      end
      // Hold off until the directed results are all back
      wait_all_results();

      // Long run of draws from one seed, idling first and then back to back
      src_gaps_on    = 1'b1;
      sink_stalls_on = 1'b1;
      drive_request(mtg_pkg::OP_SEED, $urandom, 1'b0, '0);
      for (int i = 0; i < LONG_BURST; i++) begin
         if (i == LONG_BURST / 2) begin
            src_gaps_on    = 1'b0;
            sink_stalls_on = 1'b0;
         end
         drive_request(mtg_pkg::OP_DRAW, $urandom, 1'b0, '0);
      end

      // Random bursts: mostly seed then draws, with stray reseeds mixed in
      while (rand_items < RANDOM_ITEMS) begin
         src_gaps_on    = ($urandom_range(0, 3) != 0);
         sink_stalls_on = ($urandom_range(0, 3) != 0);
         burst_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 25);
         if ($urandom_range(0, 3) != 0) begin
            drive_request(mtg_pkg::OP_SEED, pick_seed(), 1'b0, '0);
            rand_items++;
         end
         for (int i = 0; i < burst_len && rand_items < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 2) begin
               drive_request(mtg_pkg::OP_SEED, pick_seed(), 1'b0, '0);
               rand_items++;
            end
            drive_request(mtg_pkg::OP_DRAW, $urandom, 1'b0, '0);
            rand_items++;
            if ($urandom_range(0, 49) == 0) begin
               wait_all_results();
            end
         end
      end
      req_valid = 1'b0;

      // Drain and let the pipeline settle
      drain_wait = 0;
      while (pending_words.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(negedge clock);
         drain_wait++;
      end
      if (pending_words.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", pending_words.size()));
      end
      repeat (40) @(negedge clock);

      $display("covered %0d draws and %0d reseeds, %0d store regenerations",
               draws_sent, seeds_sent, regen_count);
      $display("checked %0d result transactions, %0d failures",
               checked_count, fail_count);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
